// ===== sv/cmm_pkg.sv =====
// Shared types, constants and codes of the channel min/max monitor.
package cmm_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int SAMPLE_BITS      = 12;
    localparam int ROW_LIMIT        = 16;
    localparam int CC_SHIFT         = SAMPLE_BITS - 7;

    localparam logic [15:0] MIN_CLEAR    = 16'hffff;
    localparam logic [15:0] MAX_CLEAR    = 16'h0000;
    localparam logic [6:0]  CC_BASE      = 7'h10;
    localparam logic [15:0] PERIOD_RESET = 16'd1000;

    // configuration register indexes
    localparam logic [1:0] REG_MONITOR_ENABLE = 2'd0;
    localparam logic [1:0] REG_CC_ENABLE      = 2'd1;
    localparam logic [1:0] REG_REPORT_PERIOD  = 2'd2;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;
    localparam logic KIND_CC     = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [7:0]             channel;
        logic [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  row_channel;
        logic [6:0]  cc_number;
        logic [6:0]  cc_value;
        logic [15:0] min_value;
        logic [15:0] max_value;
        logic [15:0] spread;
        logic        min_seen;
        logic        max_seen;
        logic        spread_valid;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] min_value;
        logic [15:0] max_value;
    } entry_t;

    typedef struct packed {
        logic wr_en;
        logic clr;
    } tbl_ctl_t;

    typedef struct packed {
        logic [16:0] a;
        logic [16:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [16:0] diff;
        logic        borrow;
    } alu_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIN,
        ST_MAX,
        ST_TICK,
        ST_ROW_READ,
        ST_ROW,
        ST_OUT
    } state_t;

endpackage

// ===== sv/cmm_alu.sv =====
// Shared subtract/compare unit: a minus b with borrow.
module cmm_alu
    import cmm_pkg::*;
(
    input  alu_req_t req,
    output alu_res_t res
);

    logic [17:0] full;

    assign full       = {1'b0, req.a} - {1'b0, req.b};
    assign res.diff   = full[16:0];
    assign res.borrow = full[17];

endmodule

// ===== sv/cmm_table.sv =====
// Min/max table memory with per-entry valid bits standing in for the clear value.
module cmm_table
    import cmm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_ctl_t         ctl,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    output entry_t           rd_data
);

    entry_t                  mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    entry_t                  q_reg;
    logic                    q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= valid_reg[rd_addr];
            if (ctl.clr)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // an entry never written since the last clear reads as the clear pair
    always_comb
    begin
        if (q_valid_reg)
        begin
            rd_data = q_reg;
        end
        else
        begin
            rd_data.min_value = MIN_CLEAR;
            rd_data.max_value = MAX_CLEAR;
        end
    end

endmodule

// ===== sv/cmm_ctrl.sv =====
// Sequencer: configuration registers, tick counter, update and report steps.
module cmm_ctrl
    import cmm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output tbl_ctl_t         tbl_ctl,
    output logic [IDX_W-1:0] rd_addr,
    output logic [IDX_W-1:0] wr_addr,
    output entry_t           wr_data,
    input  entry_t           rd_data,
    output alu_req_t         alu_req,
    input  alu_res_t         alu_res
);

    localparam int ROWS  = (NUM_CHANNELS < ROW_LIMIT) ? NUM_CHANNELS : ROW_LIMIT;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    state_t           state_reg,   state_next;
    in_item_t         item_reg,    item_next;
    logic [IDX_W-1:0] addr_reg,    addr_next;
    logic [ROW_W-1:0] row_reg,     row_next;
    logic [15:0]      min_new_reg, min_new_next;
    logic [15:0]      tick_reg,    tick_next;
    out_item_t        out_reg,     out_next;
    logic             monitor_reg;
    logic             cc_reg;
    logic [15:0]      period_reg;

    logic [15:0] smp16;
    logic        chan_ok;
    logic        in_beat;
    logic        row_last;

    assign smp16    = 16'(item_reg.sample);
    assign chan_ok  = {1'b0, in_data.channel} < 9'(NUM_CHANNELS);
    assign in_beat  = in_valid && (state_reg == ST_IDLE);
    assign row_last = row_reg == ROW_W'(ROWS - 1);

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    assign out_data  = out_reg;
    assign wr_addr   = addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            monitor_reg <= 1'b1;
            cc_reg      <= 1'b0;
            period_reg  <= PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MONITOR_ENABLE: monitor_reg <= cfg_data[0];
                REG_CC_ENABLE:      cc_reg      <= cfg_data[0];
                REG_REPORT_PERIOD:  period_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tick_reg  <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        addr_reg    <= addr_next;
        min_new_reg <= min_new_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        addr_next    = addr_reg;
        row_next     = row_reg;
        min_new_next = min_new_reg;
        tick_next    = tick_reg;
        out_next     = out_reg;
        tbl_ctl      = '0;
        rd_addr      = addr_reg;
        wr_data      = rd_data;
        alu_req      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // start the table read at the incoming channel right away
                rd_addr = in_data.channel[IDX_W-1:0];
                if (in_beat)
                begin
                    item_next = in_data;
                    addr_next = in_data.channel[IDX_W-1:0];
                    if (in_data.func == FUNC_TICK)
                    begin
                        state_next = ST_TICK;
                    end
                    else if (chan_ok)
                    begin
                        state_next = ST_MIN;
                    end
                end
            end

            ST_MIN:
            begin
                alu_req.a    = {1'b0, smp16};
                alu_req.b    = {1'b0, rd_data.min_value};
                min_new_next = alu_res.borrow ? smp16 : rd_data.min_value;
                state_next   = ST_MAX;
            end

            ST_MAX:
            begin
                alu_req.a         = {1'b0, rd_data.max_value};
                alu_req.b         = {1'b0, smp16};
                wr_data.min_value = min_new_reg;
                wr_data.max_value = alu_res.borrow ? smp16 : rd_data.max_value;
                tbl_ctl.wr_en     = 1'b1;
                out_next              = '0;
                out_next.kind         = KIND_CC;
                out_next.row_channel  = item_reg.channel[3:0];
                out_next.cc_number    = item_reg.channel[6:0] + CC_BASE;
                out_next.cc_value     = item_reg.sample[SAMPLE_BITS-1 -: 7];
                out_next.last         = 1'b1;
                state_next = cc_reg ? ST_OUT : ST_IDLE;
            end

            ST_TICK:
            begin
                alu_req.a = 17'(tick_reg) + 17'd1;
                alu_req.b = {1'b0, period_reg};
                if (alu_res.borrow)
                begin
                    tick_next  = tick_reg + 16'd1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    tick_next = '0;
                    if (monitor_reg)
                    begin
                        row_next   = '0;
                        addr_next  = '0;
                        state_next = ST_ROW_READ;
                    end
                    else
                    begin
                        tbl_ctl.clr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end

            ST_ROW_READ:
            begin
                // wait out the registered read
                state_next = ST_ROW;
            end

            ST_ROW:
            begin
                alu_req.a = {1'b0, rd_data.max_value};
                alu_req.b = {1'b0, rd_data.min_value};
                out_next              = '0;
                out_next.kind         = KIND_ROW;
                out_next.row_channel  = 4'(row_reg);
                out_next.min_value    = rd_data.min_value;
                out_next.max_value    = rd_data.max_value;
                out_next.spread       = alu_res.borrow ? 16'd0 : alu_res.diff[15:0];
                out_next.min_seen     = rd_data.min_value != MIN_CLEAR;
                out_next.max_seen     = rd_data.max_value != MAX_CLEAR;
                out_next.spread_valid = !alu_res.borrow;
                out_next.last         = row_last;
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (out_reg.kind == KIND_CC)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (row_last)
                    begin
                        tbl_ctl.clr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        addr_next  = IDX_W'(row_reg + 1'b1);
                        state_next = ST_ROW_READ;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/channel_min_max_jitter_monitor_unit.sv =====
// Sample beat: ST_MIN, then ST_MAX writes the update; with CC enabled the event beat shows at that same edge.
// Ready returns once the event beat is taken, or as ST_MAX ends when no event is sent.
// Tick beat: ST_TICK; at period end each report row runs ST_ROW_READ, ST_ROW and ST_OUT, which waits for out_ready.
// All steps run one at a time through the shared subtract unit and the table read port.
// Reset (async, active low) clears the table valid bits at once, so no clearing pass runs.
module channel_min_max_jitter_monitor_unit
    import cmm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    tbl_ctl_t         tbl_ctl;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           rd_data;
    alu_req_t         alu_req;
    alu_res_t         alu_res;

    assign cfg_ready = 1'b1;

    cmm_alu u_alu
    (
        .req (alu_req),
        .res (alu_res)
    );

    cmm_table #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tbl_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    cmm_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tbl_ctl   (tbl_ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_data   (rd_data),
        .alu_req   (alu_req),
        .alu_res   (alu_res)
    );

endmodule
